// ===== hdl/lsdrs_pkg.sv =====
// Shared constants for the LSD decimal radix sorter.
// Used by the BCD converter and the top level.
package lsdrs_pkg;

    localparam int KEY_W        = 31;
    localparam int PASS_W       = 4;
    localparam int NUM_DIGITS   = 10;
    localparam int DIGIT_W      = 4;
    localparam int BCD_W        = NUM_DIGITS * DIGIT_W;
    localparam int DD_STEP      = 4;
    localparam int MAX_KEYS_DEF = 64;
    localparam int KEY_BITS_DEF = 31;

    localparam logic [PASS_W-1:0] PASSES_RESET = PASS_W'(NUM_DIGITS);
    localparam logic [PASS_W-1:0] LAST_DIGIT   = PASS_W'(NUM_DIGITS - 1);

endpackage

// ===== hdl/lsdrs_bcd_conv.sv =====
// Binary to BCD converter, shift-and-add-3, DD_STEP bits per cycle.
// Depends on lsdrs_pkg for digit count and step size.
module lsdrs_bcd_conv #(
    parameter int KEY_BITS = lsdrs_pkg::KEY_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [KEY_BITS-1:0]          key,
    output logic                         done,
    output logic [lsdrs_pkg::BCD_W-1:0]  bcd
);

    localparam int STEP   = lsdrs_pkg::DD_STEP;
    localparam int STEPS  = (KEY_BITS + STEP - 1) / STEP;
    localparam int PAD    = STEPS * STEP;
    localparam int BCD_W  = lsdrs_pkg::BCD_W;
    localparam int DW     = lsdrs_pkg::DIGIT_W;
    localparam int ND     = lsdrs_pkg::NUM_DIGITS;
    localparam int SCNT_W = $clog2(STEPS + 1);

    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [PAD-1:0]    sh_reg, sh_next;
    logic [SCNT_W-1:0] cnt_reg;

    always_comb
    begin
        bcd_next = bcd_reg;
        sh_next  = sh_reg;
        for (int k = 0; k < STEP; k++)
        begin
            for (int j = 0; j < ND; j++)
            begin
                if (bcd_next[j*DW +: DW] >= DW'(5))
                begin
                    bcd_next[j*DW +: DW] = bcd_next[j*DW +: DW] + DW'(3);
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], sh_next[PAD-1]};
            sh_next  = {sh_next[PAD-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= SCNT_W'(STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - SCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bcd_reg <= '0;
            sh_reg  <= PAD'(key);
        end
        else if (cnt_reg != '0)
        begin
            bcd_reg <= bcd_next;
            sh_reg  <= sh_next;
        end
    end

    assign done = (cnt_reg == '0);
    assign bcd  = bcd_reg;

endmodule

// ===== hdl/lsdrs_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
// No package dependency.
module lsdrs_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 71
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/lsd_decimal_radix_sorter.sv =====
// LSD decimal radix sorter. Keys are loaded one per start transaction; each key is converted
// to BCD on entry (busy stays high during the conversion, so no further key is taken until this
// one is stored) and stored with its digits. A key marked last starts the sort: each of
// min(digit_passes,10) passes builds the bucket prefix sum one bucket at a time, then streams
// the n keys from one key RAM to the other. Results then leave at one per cycle through the
// output registers, each shown for one cycle with out_valid; the receiver cannot stall.
module lsd_decimal_radix_sorter #(
    parameter int MAX_KEYS = lsdrs_pkg::MAX_KEYS_DEF,
    parameter int KEY_BITS = lsdrs_pkg::KEY_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lsdrs_pkg::KEY_W-1:0]  in_key,
    input  logic                         in_last,
    input  logic                         digit_passes_we,
    input  logic [lsdrs_pkg::PASS_W-1:0] digit_passes_wdata,
    output logic                         out_valid,
    output logic [lsdrs_pkg::KEY_W-1:0]  out_key,
    output logic                         out_last,
    output logic                         overflow
);

    localparam int KEY_W   = lsdrs_pkg::KEY_W;
    localparam int PASS_W  = lsdrs_pkg::PASS_W;
    localparam int ND      = lsdrs_pkg::NUM_DIGITS;
    localparam int DW      = lsdrs_pkg::DIGIT_W;
    localparam int BCD_W   = lsdrs_pkg::BCD_W;
    localparam int CNT_W   = $clog2(MAX_KEYS + 1);
    localparam int ADDR_W  = $clog2(MAX_KEYS);
    localparam int ENTRY_W = KEY_BITS + BCD_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CONV   = 5'b00010,
        S_PREFIX = 5'b00100,
        S_PLACE  = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [PASS_W-1:0]   digit_passes_reg;
    logic [PASS_W-1:0]   passes_reg, passes_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic [PASS_W-1:0]   pfx_reg, pfx_next;
    logic [CNT_W-1:0]    key_count_reg, key_count_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    count_reg [ND];
    logic [CNT_W-1:0]    count_next [ND];
    logic [CNT_W-1:0]    pos_reg [ND];
    logic [CNT_W-1:0]    pos_next [ND];
    logic                dropped_reg, dropped_next;
    logic                last_reg, last_next;
    logic                pl_vld_reg, pl_vld_next;
    logic                rsel_reg, rsel_next;
    logic                em_vld_reg, em_vld_next;
    logic                em_last_reg, em_last_next;
    logic                em_ovf_reg, em_ovf_next;
    logic                out_valid_reg;
    logic [KEY_W-1:0]    out_key_reg;
    logic                out_last_reg, out_ovf_reg;
    logic [KEY_BITS-1:0] key_hold_reg, key_hold_next;

    logic                conv_start, conv_done;
    logic [BCD_W-1:0]    conv_bcd;
    logic [PASS_W-1:0]   passes_eff;
    logic [PASS_W-1:0]   next_pass_idx;
    logic [ENTRY_W-1:0]  rd_entry, rdata0, rdata1;
    logic [DW-1:0]       cur_digit, nxt_digit;
    logic                store_we;
    logic                we0, we1;
    logic [ADDR_W-1:0]   waddr0, wplace_addr, raddr;
    logic [ENTRY_W-1:0]  wdata0;

    lsdrs_bcd_conv #(
        .KEY_BITS (KEY_BITS)
    ) u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .key   (key_hold_next),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    lsdrs_ram #(
        .DEPTH  (MAX_KEYS),
        .DATA_W (ENTRY_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr0),
        .wdata (wdata0),
        .raddr (raddr),
        .rdata (rdata0)
    );

    lsdrs_ram #(
        .DEPTH  (MAX_KEYS),
        .DATA_W (ENTRY_W)
    ) u_scratch_ram (
        .clk   (clk),
        .we    (we1),
        .waddr (wplace_addr),
        .wdata (rd_entry),
        .raddr (raddr),
        .rdata (rdata1)
    );

    assign passes_eff    = (digit_passes_reg > lsdrs_pkg::PASSES_RESET) ?
                           lsdrs_pkg::PASSES_RESET : digit_passes_reg;
    assign next_pass_idx = (pass_reg < lsdrs_pkg::LAST_DIGIT) ?
                           pass_reg + PASS_W'(1) : pass_reg;
    assign rd_entry      = rsel_reg ? rdata1 : rdata0;
    assign cur_digit     = rd_entry[KEY_BITS + int'(pass_reg) * DW +: DW];
    assign nxt_digit     = rd_entry[KEY_BITS + int'(next_pass_idx) * DW +: DW];
    assign wplace_addr   = pos_reg[cur_digit][ADDR_W-1:0];
    assign raddr         = rd_idx_reg[ADDR_W-1:0];

    assign store_we = (state_reg == S_CONV) && conv_done;
    assign we0      = store_we || (pl_vld_reg && pass_reg[0]);
    assign we1      = pl_vld_reg && !pass_reg[0];
    assign waddr0   = store_we ? key_count_reg[ADDR_W-1:0] : wplace_addr;
    assign wdata0   = store_we ? {conv_bcd, key_hold_reg} : rd_entry;

    always_comb
    begin
        state_next     = state_reg;
        passes_next    = passes_reg;
        pass_next      = pass_reg;
        pfx_next       = pfx_reg;
        key_count_next = key_count_reg;
        rd_idx_next    = rd_idx_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        dropped_next   = dropped_reg;
        last_next      = last_reg;
        key_hold_next  = key_hold_reg;
        pl_vld_next    = 1'b0;
        em_vld_next    = 1'b0;
        em_last_next   = 1'b0;
        em_ovf_next    = dropped_reg;
        rsel_next      = (state_reg == S_EMIT) ? passes_reg[0] : pass_reg[0];
        conv_start     = 1'b0;

        // bucket placement of the key read last cycle, and count of its next digit
        if (pl_vld_reg)
        begin
            pos_next[cur_digit] = pos_reg[cur_digit] + CNT_W'(1);
            if (pass_reg < lsdrs_pkg::LAST_DIGIT)
            begin
                count_next[nxt_digit] = count_reg[nxt_digit] + CNT_W'(1);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    last_next = in_last;
                    if (key_count_reg == CNT_W'(MAX_KEYS))
                    begin
                        dropped_next = 1'b1;
                        if (in_last)
                        begin
                            passes_next = passes_eff;
                            pass_next   = '0;
                            pfx_next    = '0;
                            total_next  = '0;
                            rd_idx_next = '0;
                            state_next  = (passes_eff == '0) ? S_EMIT : S_PREFIX;
                        end
                    end
                    else
                    begin
                        key_hold_next = in_key[KEY_BITS-1:0];
                        conv_start    = 1'b1;
                        state_next    = S_CONV;
                    end
                end
            end

            S_CONV:
            begin
                if (conv_done)
                begin
                    key_count_next = key_count_reg + CNT_W'(1);
                    count_next[conv_bcd[DW-1:0]] = count_reg[conv_bcd[DW-1:0]] + CNT_W'(1);
                    if (last_reg)
                    begin
                        passes_next = passes_eff;
                        pass_next   = '0;
                        pfx_next    = '0;
                        total_next  = '0;
                        rd_idx_next = '0;
                        state_next  = (passes_eff == '0) ? S_EMIT : S_PREFIX;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_PREFIX:
            begin
                // turn counts into bucket start positions, one bucket a cycle
                pos_next[pfx_reg]   = total_reg;
                total_next          = total_reg + count_reg[pfx_reg];
                count_next[pfx_reg] = '0;
                if (pfx_reg == lsdrs_pkg::LAST_DIGIT)
                begin
                    rd_idx_next = '0;
                    state_next  = S_PLACE;
                end
                else
                begin
                    pfx_next = pfx_reg + PASS_W'(1);
                end
            end

            S_PLACE:
            begin
                if (rd_idx_reg < key_count_reg)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    pl_vld_next = 1'b1;
                end
                else if (!pl_vld_reg)
                begin
                    // pipeline drained: advance to the next pass or emit
                    rd_idx_next = '0;
                    if (pass_reg + PASS_W'(1) == passes_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        pass_next  = pass_reg + PASS_W'(1);
                        pfx_next   = '0;
                        total_next = '0;
                        state_next = S_PREFIX;
                    end
                end
            end

            S_EMIT:
            begin
                for (int i = 0; i < ND; i++)
                begin
                    count_next[i] = '0;
                end
                em_vld_next  = 1'b1;
                em_last_next = (rd_idx_reg == key_count_reg - CNT_W'(1));
                rd_idx_next  = rd_idx_reg + CNT_W'(1);
                if (em_last_next)
                begin
                    key_count_next = '0;
                    dropped_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            digit_passes_reg <= lsdrs_pkg::PASSES_RESET;
            passes_reg       <= '0;
            pass_reg         <= '0;
            pfx_reg          <= '0;
            key_count_reg    <= '0;
            rd_idx_reg       <= '0;
            total_reg        <= '0;
            dropped_reg      <= 1'b0;
            last_reg         <= 1'b0;
            pl_vld_reg       <= 1'b0;
            rsel_reg         <= 1'b0;
            em_vld_reg       <= 1'b0;
            em_last_reg      <= 1'b0;
            em_ovf_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_last_reg     <= 1'b0;
            out_ovf_reg      <= 1'b0;
            for (int i = 0; i < ND; i++)
            begin
                count_reg[i] <= '0;
                pos_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            if (digit_passes_we)
            begin
                digit_passes_reg <= digit_passes_wdata;
            end
            passes_reg    <= passes_next;
            pass_reg      <= pass_next;
            pfx_reg       <= pfx_next;
            key_count_reg <= key_count_next;
            rd_idx_reg    <= rd_idx_next;
            total_reg     <= total_next;
            dropped_reg   <= dropped_next;
            last_reg      <= last_next;
            pl_vld_reg    <= pl_vld_next;
            rsel_reg      <= rsel_next;
            em_vld_reg    <= em_vld_next;
            em_last_reg   <= em_last_next;
            em_ovf_reg    <= em_ovf_next;
            out_valid_reg <= em_vld_reg;
            out_last_reg  <= em_vld_reg && em_last_reg;
            out_ovf_reg   <= em_vld_reg && em_ovf_reg;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_hold_reg <= key_hold_next;
        out_key_reg  <= KEY_W'(rd_entry[KEY_BITS-1:0]);
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_last  = out_last_reg;
    assign overflow  = out_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= CNT_W'(MAX_KEYS))
        else $error("key count beyond capacity");

    a_place_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pl_vld_reg |-> (pos_reg[cur_digit] < key_count_reg))
        else $error("bucket position beyond key count");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLACE) |-> (pass_reg < passes_reg))
        else $error("pass index beyond pass count");

    a_last_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |=> !out_valid)
        else $error("result transaction after the final one of a set");

endmodule
